@@ rtl/core/eebd_pkg.sv @@
// ============================================================================
// eebd_pkg
// Shared types, constants and helpers for the early-exit budget decider.
// ============================================================================
package eebd_pkg;

    localparam int FRAC_BITS      = 12;
    localparam int UNC_HIGH_LEVEL = 4096;
    localparam int SCORE_W        = 24;
    localparam int ACC_W          = SCORE_W + FRAC_BITS;
    localparam int CFG_DATA_W     = 24;
    localparam int CFG_INDEX_W    = 3;

    typedef enum logic [1:0] {
        VERDICT_CONTINUE = 2'd0,
        VERDICT_EXIT     = 2'd1,
        VERDICT_EXPAND   = 2'd2,
        VERDICT_ABSTAIN  = 2'd3
    } verdict_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_STEP_CAP      = 3'd0,
        REG_STEP_FLOOR    = 3'd1,
        REG_W_REDUCIBLE   = 3'd2,
        REG_W_STABLE      = 3'd3,
        REG_W_REFLECT     = 3'd4,
        REG_W_IRREDUCIBLE = 3'd5,
        REG_READY_THRESH  = 3'd6,
        REG_DOM_THRESH    = 3'd7
    } cfg_index_t;

    localparam logic [15:0] RST_STEP_CAP      = 16'd32;
    localparam logic [15:0] RST_STEP_FLOOR    = 16'd2;
    localparam logic [15:0] RST_W_REDUCIBLE   = 16'd4096;
    localparam logic [15:0] RST_W_STABLE      = 16'd3072;
    localparam logic [15:0] RST_W_REFLECT     = 16'd1024;
    localparam logic [15:0] RST_W_IRREDUCIBLE = 16'd6144;
    localparam logic [23:0] RST_READY_THRESH  = 24'd2048;
    localparam logic [12:0] RST_DOM_THRESH    = 13'd2662;

    // ready_threshold is held as raw bits, read through $signed
    typedef struct packed {
        logic [15:0] step_cap;
        logic [15:0] step_floor;
        logic [15:0] w_reducible;
        logic [15:0] w_stable;
        logic [15:0] w_reflect;
        logic [15:0] w_irreducible;
        logic [23:0] ready_threshold;
        logic [12:0] dominance_threshold;
    } cfg_t;

    // registered products handed from the multiply stage to the decision stage
    typedef struct packed {
        logic        new_trace;
        logic [34:0] p_stable;      // signed
        logic [31:0] p_reflect;
        logic [31:0] p_reducible;
        logic [31:0] p_irreducible;
        logic [29:0] p_dominance;
        logic [15:0] reducible;
        logic [15:0] irreducible;
        logic [16:0] total;
    } prod_t;

    function automatic logic [15:0] sat_inc16(input logic [15:0] a);
        sat_inc16 = (a == 16'hFFFF) ? 16'hFFFF : a + 16'd1;
    endfunction

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'd0, b};
        sat_add32 = s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

@@ rtl/core/eebd_cfg.sv @@
// ============================================================================
// eebd_cfg
// Configuration register file, written through a plain write port.
// ============================================================================
module eebd_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [eebd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [eebd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output eebd_pkg::cfg_t                     cfg
);

    eebd_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_cap            <= eebd_pkg::RST_STEP_CAP;
            cfg_reg.step_floor          <= eebd_pkg::RST_STEP_FLOOR;
            cfg_reg.w_reducible         <= eebd_pkg::RST_W_REDUCIBLE;
            cfg_reg.w_stable            <= eebd_pkg::RST_W_STABLE;
            cfg_reg.w_reflect           <= eebd_pkg::RST_W_REFLECT;
            cfg_reg.w_irreducible       <= eebd_pkg::RST_W_IRREDUCIBLE;
            cfg_reg.ready_threshold     <= eebd_pkg::RST_READY_THRESH;
            cfg_reg.dominance_threshold <= eebd_pkg::RST_DOM_THRESH;
        end else if (cfg_we) begin
            case (eebd_pkg::cfg_index_t'(cfg_index))
                eebd_pkg::REG_STEP_CAP:      cfg_reg.step_cap      <= cfg_wdata[15:0];
                eebd_pkg::REG_STEP_FLOOR:    cfg_reg.step_floor    <= cfg_wdata[15:0];
                eebd_pkg::REG_W_REDUCIBLE:   cfg_reg.w_reducible   <= cfg_wdata[15:0];
                eebd_pkg::REG_W_STABLE:      cfg_reg.w_stable      <= cfg_wdata[15:0];
                eebd_pkg::REG_W_REFLECT:     cfg_reg.w_reflect     <= cfg_wdata[15:0];
                eebd_pkg::REG_W_IRREDUCIBLE: cfg_reg.w_irreducible <= cfg_wdata[15:0];
                eebd_pkg::REG_READY_THRESH:  cfg_reg.ready_threshold <= cfg_wdata[23:0];
                eebd_pkg::REG_DOM_THRESH:    cfg_reg.dominance_threshold <= cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/eebd_prod.sv @@
// ============================================================================
// eebd_prod
// Input register and product stage: the weighted terms and the dominance
// product, registered for the decision stage.
// ============================================================================
module eebd_prod (
    input  logic            aclk,
    input  logic            aresetn,
    input  eebd_pkg::cfg_t  cfg,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_new_trace,
    input  logic [15:0]     s_uncertainty_reducible,
    input  logic [15:0]     s_uncertainty_irreducible,
    input  logic [15:0]     s_answer_change,
    input  logic [15:0]     s_reflection_level,
    output logic            prod_valid,
    input  logic            prod_ready,
    output eebd_pkg::prod_t prod
);

    localparam logic [17:0] ONE_Q = 18'(1 << eebd_pkg::FRAC_BITS);

    logic        in_valid_reg;
    logic        in_new_trace_reg;
    logic [15:0] in_red_reg;
    logic [15:0] in_irr_reg;
    logic [15:0] in_chg_reg;
    logic [15:0] in_refl_reg;

    logic            prod_valid_reg;
    eebd_pkg::prod_t prod_reg;
    eebd_pkg::prod_t prod_next;

    logic        ready_prod;
    logic        ready_in;
    logic signed [17:0] stable_term;

    assign ready_prod = !prod_valid_reg || prod_ready;
    assign ready_in   = !in_valid_reg || ready_prod;
    assign s_ready    = ready_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (ready_in) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_in && s_valid) begin
            in_new_trace_reg <= s_new_trace;
            in_red_reg       <= s_uncertainty_reducible;
            in_irr_reg       <= s_uncertainty_irreducible;
            in_chg_reg       <= s_answer_change;
            in_refl_reg      <= s_reflection_level;
        end
    end

    // one minus answer change, may go negative
    assign stable_term = $signed(ONE_Q) - $signed({2'b00, in_chg_reg});

    always_comb begin
        logic signed [34:0] p_stable;
        p_stable = $signed({1'b0, cfg.w_stable}) * stable_term;
        prod_next.new_trace     = in_new_trace_reg;
        prod_next.p_stable      = p_stable;
        prod_next.p_reflect     = cfg.w_reflect * in_refl_reg;
        prod_next.p_reducible   = cfg.w_reducible * in_red_reg;
        prod_next.p_irreducible = cfg.w_irreducible * in_irr_reg;
        prod_next.reducible     = in_red_reg;
        prod_next.irreducible   = in_irr_reg;
        prod_next.total         = {1'b0, in_red_reg} + {1'b0, in_irr_reg};
        prod_next.p_dominance   = cfg.dominance_threshold * prod_next.total;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (ready_prod) begin
            prod_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_prod && in_valid_reg) begin
            prod_reg <= prod_next;
        end
    end

    assign prod_valid = prod_valid_reg;
    assign prod       = prod_reg;

endmodule

@@ rtl/core/eebd_decide.sv @@
// ============================================================================
// eebd_decide
// Decision stage: readiness sum, verdict, trace state and result register.
// ============================================================================
module eebd_decide (
    input  logic            aclk,
    input  logic            aresetn,
    input  eebd_pkg::cfg_t  cfg,
    input  logic            prod_valid,
    output logic            prod_ready,
    input  eebd_pkg::prod_t prod,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [1:0]      m_verdict,
    output logic [23:0]     m_readiness,
    output logic [15:0]     m_steps_seen,
    output logic [15:0]     m_n_continue,
    output logic [15:0]     m_n_exit,
    output logic [15:0]     m_n_expand,
    output logic [15:0]     m_n_abstain,
    output logic [31:0]     m_sum_reducible,
    output logic [31:0]     m_sum_irreducible
);

    localparam logic [16:0] HIGH_TOTAL = 17'(eebd_pkg::UNC_HIGH_LEVEL);

    // the result register doubles as the trace state
    logic        m_valid_reg;
    logic [15:0] step_reg;
    logic [15:0] count_reg [4];
    logic [31:0] sum_red_reg;
    logic [31:0] sum_irr_reg;
    logic [1:0]  verdict_reg;
    logic [23:0] readiness_reg;

    logic [15:0] step_next;
    logic [15:0] count_next [4];
    logic [31:0] sum_red_next;
    logic [31:0] sum_irr_next;
    eebd_pkg::verdict_t verdict_next;
    logic [23:0] readiness_next;

    logic load;

    assign prod_ready = !m_valid_reg || m_ready;
    assign load       = prod_valid && prod_ready;

    always_comb begin
        logic signed [eebd_pkg::ACC_W-1:0] acc;
        logic [15:0] step_base;
        logic [29:0] irr_scaled;
        logic ready, high, dom, past_floor, at_cap;

        acc = eebd_pkg::ACC_W'($signed(prod.p_stable))
            + $signed({4'b0000, prod.p_reflect})
            - $signed({4'b0000, prod.p_reducible})
            - $signed({4'b0000, prod.p_irreducible});
        // the sum always fits the score range, so the floor shift is a slice
        readiness_next = acc[eebd_pkg::ACC_W-1:eebd_pkg::FRAC_BITS];

        step_base    = prod.new_trace ? 16'd0 : step_reg;
        step_next    = eebd_pkg::sat_inc16(step_base);
        sum_red_next = eebd_pkg::sat_add32(prod.new_trace ? 32'd0 : sum_red_reg,
                                           prod.reducible);
        sum_irr_next = eebd_pkg::sat_add32(prod.new_trace ? 32'd0 : sum_irr_reg,
                                           prod.irreducible);

        irr_scaled = {2'b00, prod.irreducible, {eebd_pkg::FRAC_BITS{1'b0}}};
        past_floor = step_next >= cfg.step_floor;
        at_cap     = step_next >= cfg.step_cap;
        ready      = $signed(readiness_next) >= $signed(cfg.ready_threshold);
        high       = prod.total >= HIGH_TOTAL;
        if (prod.total == 17'd0) begin
            dom = cfg.dominance_threshold == 13'd0;
        end else begin
            dom = irr_scaled >= prod.p_dominance;
        end

        if (at_cap) begin
            verdict_next = eebd_pkg::VERDICT_EXIT;
        end else if (high && dom && past_floor) begin
            verdict_next = eebd_pkg::VERDICT_ABSTAIN;
        end else if (high && !dom) begin
            verdict_next = eebd_pkg::VERDICT_EXPAND;
        end else if (ready && past_floor) begin
            verdict_next = eebd_pkg::VERDICT_EXIT;
        end else begin
            verdict_next = eebd_pkg::VERDICT_CONTINUE;
        end

        for (int i = 0; i < 4; i++) begin
            count_next[i] = prod.new_trace ? 16'd0 : count_reg[i];
            if (verdict_next == eebd_pkg::verdict_t'(i)) begin
                count_next[i] = eebd_pkg::sat_inc16(count_next[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            step_reg    <= 16'd0;
            sum_red_reg <= 32'd0;
            sum_irr_reg <= 32'd0;
            for (int i = 0; i < 4; i++) begin
                count_reg[i] <= 16'd0;
            end
        end else begin
            if (prod_ready) begin
                m_valid_reg <= prod_valid;
            end
            if (load) begin
                step_reg    <= step_next;
                sum_red_reg <= sum_red_next;
                sum_irr_reg <= sum_irr_next;
                for (int i = 0; i < 4; i++) begin
                    count_reg[i] <= count_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            verdict_reg   <= verdict_next;
            readiness_reg <= readiness_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_verdict         = verdict_reg;
    assign m_readiness       = readiness_reg;
    assign m_steps_seen      = step_reg;
    assign m_n_continue      = count_reg[eebd_pkg::VERDICT_CONTINUE];
    assign m_n_exit          = count_reg[eebd_pkg::VERDICT_EXIT];
    assign m_n_expand        = count_reg[eebd_pkg::VERDICT_EXPAND];
    assign m_n_abstain       = count_reg[eebd_pkg::VERDICT_ABSTAIN];
    assign m_sum_reducible   = sum_red_reg;
    assign m_sum_irreducible = sum_irr_reg;

endmodule

@@ rtl/core/early_exit_budget_decider_unit.sv @@
// ============================================================================
// early_exit_budget_decider_unit
// Per-step early-exit decider: readiness score, verdict and trace statistics.
// ============================================================================
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+---------------------------------
//   s_       | in        | s_valid / s_ready | new_trace, four Q4.12 signals
//   m_       | out       | m_valid / m_ready | verdict, readiness, counts, sums
//   cfg_     | in        | cfg_we            | cfg_index, cfg_wdata (no read)
//
// three register stages: input beat, products, result; one beat is taken
// per cycle while the result side keeps up.
// the trace state (step counter, verdict counts, totals) lives in the result
// register and is updated as a beat enters it.
// synchronous active-low reset clears the valids, the trace state and loads
// the register defaults; a stalled result holds, and the stall backs up
// stage by stage to s_ready.
//
module early_exit_budget_decider_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_we,
    input  logic [eebd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [eebd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // step beats
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_new_trace,
    input  logic [15:0]                        s_uncertainty_reducible,
    input  logic [15:0]                        s_uncertainty_irreducible,
    input  logic [15:0]                        s_answer_change,
    input  logic [15:0]                        s_reflection_level,
    // verdict beats
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_verdict,
    output logic [23:0]                        m_readiness,
    output logic [15:0]                        m_steps_seen,
    output logic [15:0]                        m_n_continue,
    output logic [15:0]                        m_n_exit,
    output logic [15:0]                        m_n_expand,
    output logic [15:0]                        m_n_abstain,
    output logic [31:0]                        m_sum_reducible,
    output logic [31:0]                        m_sum_irreducible
);

    eebd_pkg::cfg_t  cfg;
    eebd_pkg::prod_t prod;
    logic            prod_valid;
    logic            prod_ready;

    // register file; write it only while no beat is in flight (the block does not enforce this)
    eebd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // input register, then four weight products and the dominance product
    eebd_prod u_prod (
        .aclk                      (aclk),
        .aresetn                   (aresetn),
        .cfg                       (cfg),
        .s_valid                   (s_valid),
        .s_ready                   (s_ready),
        .s_new_trace               (s_new_trace),
        .s_uncertainty_reducible   (s_uncertainty_reducible),
        .s_uncertainty_irreducible (s_uncertainty_irreducible),
        .s_answer_change           (s_answer_change),
        .s_reflection_level        (s_reflection_level),
        .prod_valid                (prod_valid),
        .prod_ready                (prod_ready),
        .prod                      (prod)
    );

    // score sum, priority verdict, saturating trace state, result register
    eebd_decide u_decide (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .prod_valid        (prod_valid),
        .prod_ready        (prod_ready),
        .prod              (prod),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_verdict         (m_verdict),
        .m_readiness       (m_readiness),
        .m_steps_seen      (m_steps_seen),
        .m_n_continue      (m_n_continue),
        .m_n_exit          (m_n_exit),
        .m_n_expand        (m_n_expand),
        .m_n_abstain       (m_n_abstain),
        .m_sum_reducible   (m_sum_reducible),
        .m_sum_irreducible (m_sum_irreducible)
    );

endmodule

@@ rtl/core/eebd_chk.sv @@
// ============================================================================
// eebd_chk
// Port-level checks on the decider's result channel.
// ============================================================================
module eebd_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_verdict,
    input logic [23:0] m_readiness,
    input logic [15:0] m_steps_seen,
    input logic [15:0] m_n_continue,
    input logic [15:0] m_n_exit,
    input logic [15:0] m_n_expand,
    input logic [15:0] m_n_abstain
);

    // no result beat right after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_verdict) && $stable(m_readiness))
        else $error("stalled result beat changed");

    // verdict counts add up to the step number while nothing saturates
    a_count_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_steps_seen != 16'hFFFF |->
            ({2'b00, m_n_continue} + {2'b00, m_n_exit} + {2'b00, m_n_expand}
             + {2'b00, m_n_abstain}) == {2'b00, m_steps_seen})
        else $error("verdict counts do not match step number");

    // the verdict of a beat is counted in its own count
    a_verdict_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            (m_verdict == eebd_pkg::VERDICT_CONTINUE && m_n_continue != 16'd0) ||
            (m_verdict == eebd_pkg::VERDICT_EXIT     && m_n_exit     != 16'd0) ||
            (m_verdict == eebd_pkg::VERDICT_EXPAND   && m_n_expand   != 16'd0) ||
            (m_verdict == eebd_pkg::VERDICT_ABSTAIN  && m_n_abstain  != 16'd0))
        else $error("verdict missing from its count");

endmodule

bind early_exit_budget_decider_unit eebd_chk u_eebd_chk (.*);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for early_exit_budget_decider_unit. A step driver and a
// verdict monitor run as clocked processes around the block. Every accepted
// step is run through a local decider model that computes the verdict,
// readiness and trace statistics the block must return. Each result beat is
// then checked field by field against the oldest prediction.
// ============================================================================
module testbench;
    import eebd_pkg::*;

    typedef struct packed {
        logic        new_trace;
        logic [15:0] reducible;
        logic [15:0] irreducible;
        logic [15:0] change;
        logic [15:0] reflection;
    } step_beat_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [23:0] readiness;
        logic [15:0] steps_seen;
        logic [15:0] n_continue;
        logic [15:0] n_exit;
        logic [15:0] n_expand;
        logic [15:0] n_abstain;
        logic [31:0] sum_reducible;
        logic [31:0] sum_irreducible;
    } verdict_beat_t;

    // register sets used between phases
    typedef enum int {SET_RANDOM, SET_MAXIMA, SET_MINIMA} reg_set_t;

    localparam longint UNITY      = longint'(1) << FRAC_BITS;
    localparam longint SCORE_MAX  = 64'sd8388607;
    localparam longint SCORE_MIN  = -64'sd8388608;
    localparam int     LONG_STEPS = 100;     // one trace well past the step cap
    localparam int     RAND_STEPS = 235;     // random steps per register setting
    localparam int     RAND_SETS  = 8;
    localparam int     HOLD_LONG  = 300;     // receiver hold-off to back up the pipe
    localparam int     MAX_REPORTS = 100;

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                   aclk    = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    logic        s_valid                   = 1'b0;
    logic        s_ready;
    logic        s_new_trace               = 1'b0;
    logic [15:0] s_uncertainty_reducible   = '0;
    logic [15:0] s_uncertainty_irreducible = '0;
    logic [15:0] s_answer_change           = '0;
    logic [15:0] s_reflection_level        = '0;

    logic        m_valid;
    logic        m_ready = 1'b1;
    logic [1:0]  m_verdict;
    logic [23:0] m_readiness;
    logic [15:0] m_steps_seen;
    logic [15:0] m_n_continue;
    logic [15:0] m_n_exit;
    logic [15:0] m_n_expand;
    logic [15:0] m_n_abstain;
    logic [31:0] m_sum_reducible;
    logic [31:0] m_sum_irreducible;

    always #1 aclk = ~aclk;

    early_exit_budget_decider_unit u_dut (
        .aclk                      (aclk),
        .aresetn                   (aresetn),
        .cfg_we                    (cfg_we),
        .cfg_index                 (cfg_index),
        .cfg_wdata                 (cfg_wdata),
        .s_valid                   (s_valid),
        .s_ready                   (s_ready),
        .s_new_trace               (s_new_trace),
        .s_uncertainty_reducible   (s_uncertainty_reducible),
        .s_uncertainty_irreducible (s_uncertainty_irreducible),
        .s_answer_change           (s_answer_change),
        .s_reflection_level        (s_reflection_level),
        .m_valid                   (m_valid),
        .m_ready                   (m_ready),
        .m_verdict                 (m_verdict),
        .m_readiness               (m_readiness),
        .m_steps_seen              (m_steps_seen),
        .m_n_continue              (m_n_continue),
        .m_n_exit                  (m_n_exit),
        .m_n_expand                (m_n_expand),
        .m_n_abstain               (m_n_abstain),
        .m_sum_reducible           (m_sum_reducible),
        .m_sum_irreducible         (m_sum_irreducible)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    step_beat_t    steps_to_send[$];
    verdict_beat_t verdicts_due[$];

    int steps_queued   = 0;   // steps handed to the driver so far
    int steps_accepted = 0;
    int traces_started = 0;
    int result_beats   = 0;   // every result handshake, matched or not
    int mismatches     = 0;
    int settings_run   = 0;
    int verdict_seen[4] = '{0, 0, 0, 0};

    bit full_rate    = 1'b0;  // no sender gaps, no receiver stalls beyond a requested hold-off
    int hold_request = 0;     // long receiver hold-off, picked up by the monitor

    // decider model: register copy and per-trace statistics
    cfg_t        regs;
    logic [15:0] trace_step;
    logic [15:0] tally[4];
    logic [31:0] red_total;
    logic [31:0] irr_total;

    // ------------------------------------------------------------------------
    // decider model: one step in, the verdict beat it must produce out
    // ------------------------------------------------------------------------
    function automatic verdict_beat_t decide_step(step_beat_t st);
        verdict_beat_t r;
        longint        ws, wf, wr, wi, red, irr, chg, refl;
        longint        acc, score, thr, dt, tt;
        logic [16:0]   total;
        logic [32:0]   wide;
        logic          high, dom, past_floor, at_cap, ready;
        verdict_t      v;

        if (st.new_trace) begin
            trace_step = '0;
            foreach (tally[i]) tally[i] = '0;
            red_total = '0;
            irr_total = '0;
        end

        ws   = regs.w_stable;
        wf   = regs.w_reflect;
        wr   = regs.w_reducible;
        wi   = regs.w_irreducible;
        red  = st.reducible;
        irr  = st.irreducible;
        chg  = st.change;
        refl = st.reflection;

        // exact Q.24 sum, then floor back to Q.12 and clamp to 24 bits
        acc   = ws * (UNITY - chg) + wf * refl - wr * red - wi * irr;
        score = acc >>> FRAC_BITS;
        if (score > SCORE_MAX) score = SCORE_MAX;
        if (score < SCORE_MIN) score = SCORE_MIN;

        if (trace_step != 16'hFFFF) trace_step = trace_step + 16'd1;
        wide      = {1'b0, red_total} + {17'd0, st.reducible};
        red_total = wide[32] ? 32'hFFFF_FFFF : wide[31:0];
        wide      = {1'b0, irr_total} + {17'd0, st.irreducible};
        irr_total = wide[32] ? 32'hFFFF_FFFF : wide[31:0];

        total      = {1'b0, st.reducible} + {1'b0, st.irreducible};
        thr        = $signed(regs.ready_threshold);
        past_floor = trace_step >= regs.step_floor;
        at_cap     = trace_step >= regs.step_cap;
        ready      = score >= thr;
        high       = total >= UNC_HIGH_LEVEL;

        // irreducible share test by cross multiply; zero total only passes a zero threshold
        dt = regs.dominance_threshold;
        tt = total;
        if (total == '0) dom = (regs.dominance_threshold == '0);
        else dom = (irr << FRAC_BITS) >= dt * tt;

        if (at_cap) v = VERDICT_EXIT;
        else if (high && dom && past_floor) v = VERDICT_ABSTAIN;
        else if (high && !dom) v = VERDICT_EXPAND;
        else if (ready && past_floor) v = VERDICT_EXIT;
        else v = VERDICT_CONTINUE;

        if (tally[v] != 16'hFFFF) tally[v] = tally[v] + 16'd1;

        r.verdict         = v;
        r.readiness       = score[23:0];
        r.steps_seen      = trace_step;
        r.n_continue      = tally[VERDICT_CONTINUE];
        r.n_exit          = tally[VERDICT_EXIT];
        r.n_expand        = tally[VERDICT_EXPAND];
        r.n_abstain       = tally[VERDICT_ABSTAIN];
        r.sum_reducible   = red_total;
        r.sum_irreducible = irr_total;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    // levels cluster around the high-uncertainty threshold, with extremes mixed in
    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom);
            default: return 16'($urandom_range(0, 6144));
        endcase
    endfunction

    function automatic logic [23:0] pick_reg_value(cfg_index_t idx);
        logic [23:0] v;
        logic [7:0]  junk;
        // stray upper data bits must be dropped by the narrower registers
        junk = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
        case (idx)
            REG_STEP_CAP: begin
                v = ($urandom_range(0, 5) == 0) ? 24'($urandom_range(0, 65535))
                                                : 24'($urandom_range(0, 48));
                v[23:16] = junk;
            end
            REG_STEP_FLOOR: begin
                v = ($urandom_range(0, 5) == 0) ? 24'($urandom_range(0, 65535))
                                                : 24'($urandom_range(0, 12));
                v[23:16] = junk;
            end
            REG_READY_THRESH: begin
                v = ($urandom_range(0, 4) == 0) ? 24'($urandom)
                                                : 24'($urandom_range(0, 32768) - 16384);
            end
            REG_DOM_THRESH: begin
                v = ($urandom_range(0, 4) == 0) ? 24'($urandom_range(4097, 8191))
                                                : 24'($urandom_range(0, 4096));
                v[23:13] = {3'b000, junk};
            end
            default: begin
                v = ($urandom_range(0, 4) == 0) ? 24'($urandom_range(0, 65535))
                                                : 24'($urandom_range(0, 12288));
                v[23:16] = junk;
            end
        endcase
        return v;
    endfunction

    function automatic step_beat_t random_step();
        step_beat_t st;
        st.new_trace   = ($urandom_range(0, 19) == 0);
        st.reducible   = pick_level();
        st.irreducible = pick_level();
        st.change      = pick_level();
        st.reflection  = pick_level();
        return st;
    endfunction

    task automatic push_step(logic nt, logic [15:0] red, logic [15:0] irr,
                             logic [15:0] chg, logic [15:0] refl);
        steps_to_send.push_back('{nt, red, irr, chg, refl});
        steps_queued++;
    endtask

    // one register write per edge; the model follows at once since the pipe is empty
    task automatic write_reg(cfg_index_t idx, logic [23:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_STEP_CAP:      regs.step_cap            = val[15:0];
            REG_STEP_FLOOR:    regs.step_floor          = val[15:0];
            REG_W_REDUCIBLE:   regs.w_reducible         = val[15:0];
            REG_W_STABLE:      regs.w_stable            = val[15:0];
            REG_W_REFLECT:     regs.w_reflect           = val[15:0];
            REG_W_IRREDUCIBLE: regs.w_irreducible       = val[15:0];
            REG_READY_THRESH:  regs.ready_threshold     = val;
            REG_DOM_THRESH:    regs.dominance_threshold = val[12:0];
            default: ;
        endcase
    endtask

    task automatic close_writes();
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    task automatic program_regs(reg_set_t set);
        cfg_index_t  idx;
        logic [23:0] val;
        for (int i = 0; i < 8; i++) begin
            idx = cfg_index_t'(i);
            case (set)
                SET_MAXIMA: begin
                    if (idx == REG_READY_THRESH) val = 24'h7F_FFFF;
                    else if (idx == REG_DOM_THRESH) val = 24'd8191;
                    else val = 24'h00_FFFF;
                end
                SET_MINIMA: val = (idx == REG_READY_THRESH) ? 24'h80_0000 : 24'h00_0000;
                default: val = pick_reg_value(idx);
            endcase
            write_reg(idx, val);
        end
        close_writes();
    endtask

    // idle means every queued step has come back as a result beat
    task automatic wait_drained();
        while (result_beats < steps_queued) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic check_field(string field, longint want_v, longint got_v);
        if (want_v != got_v) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t ns: %s expected %0d, got %0d", $time, field, want_v, got_v);
        end
    endtask

    // ------------------------------------------------------------------------
    // step driver: bursts of back-to-back beats with random gaps between them
    // ------------------------------------------------------------------------
    int gap_left   = 0;
    int burst_left = 0;

    always @(posedge aclk) begin : drive_steps
        step_beat_t nxt;
        logic       fire;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            fire = s_valid && s_ready;
            if (fire) begin
                nxt = {s_new_trace, s_uncertainty_reducible, s_uncertainty_irreducible,
                       s_answer_change, s_reflection_level};
                verdicts_due.push_back(decide_step(nxt));
                steps_accepted++;
                if (nxt.new_trace) traces_started++;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    burst_left = $urandom_range(1, 40);
                end
            end
            // the slot frees up on a handshake or when nothing is on the wire
            if (fire || !s_valid) begin
                if ((gap_left > 0 && !full_rate) || steps_to_send.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    gap_left = 0;
                    nxt = steps_to_send.pop_front();
                    s_new_trace               <= nxt.new_trace;
                    s_uncertainty_reducible   <= nxt.reducible;
                    s_uncertainty_irreducible <= nxt.irreducible;
                    s_answer_change           <= nxt.change;
                    s_reflection_level        <= nxt.reflection;
                    s_valid                   <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // verdict monitor: checks result beats and paces m_ready
    // ------------------------------------------------------------------------
    int cycle_no   = 0;
    int stall_mode = 0;
    int hold_left  = 0;

    always @(posedge aclk) begin : watch_verdicts
        verdict_beat_t got, want;
        if (aresetn && m_valid && m_ready) begin
            result_beats++;
            got.verdict         = verdict_t'(m_verdict);
            got.readiness       = m_readiness;
            got.steps_seen      = m_steps_seen;
            got.n_continue      = m_n_continue;
            got.n_exit          = m_n_exit;
            got.n_expand        = m_n_expand;
            got.n_abstain       = m_n_abstain;
            got.sum_reducible   = m_sum_reducible;
            got.sum_irreducible = m_sum_irreducible;
            if (verdicts_due.size() == 0) begin
                mismatches++;
                $display("%0t ns: result beat with no step pending, expected none, got verdict %0d",
                         $time, m_verdict);
            end else begin
                want = verdicts_due.pop_front();
                check_field("verdict", want.verdict, got.verdict);
                check_field("readiness", longint'($signed(want.readiness)),
                            longint'($signed(got.readiness)));
                check_field("steps_seen", want.steps_seen, got.steps_seen);
                check_field("n_continue", want.n_continue, got.n_continue);
                check_field("n_exit", want.n_exit, got.n_exit);
                check_field("n_expand", want.n_expand, got.n_expand);
                check_field("n_abstain", want.n_abstain, got.n_abstain);
                check_field("sum_reducible", want.sum_reducible, got.sum_reducible);
                check_field("sum_irreducible", want.sum_irreducible, got.sum_irreducible);
                verdict_seen[got.verdict]++;
            end
        end

        // stall pattern: a random mode, redrawn periodically from the cycle counter, with a long hold-off on request
        cycle_no++;
        if (cycle_no % 128 == 0) stall_mode = $urandom_range(0, 3);
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (full_rate) begin
            m_ready <= 1'b1;
        end else begin
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                2: m_ready <= (cycle_no % 4 != 0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin : run_steps
        regs.step_cap            = RST_STEP_CAP;
        regs.step_floor          = RST_STEP_FLOOR;
        regs.w_reducible         = RST_W_REDUCIBLE;
        regs.w_stable            = RST_W_STABLE;
        regs.w_reflect           = RST_W_REFLECT;
        regs.w_irreducible       = RST_W_IRREDUCIBLE;
        regs.ready_threshold     = RST_READY_THRESH;
        regs.dominance_threshold = RST_DOM_THRESH;
        trace_step = '0;
        foreach (tally[i]) tally[i] = '0;
        red_total = '0;
        irr_total = '0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults: below floor, ready exit, abstain, expand,
        // the high-uncertainty edge from both sides, field extremes
        push_step(1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
        push_step(1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
        push_step(1'b0, 16'd0, 16'd8192, 16'd0, 16'd0);
        push_step(1'b0, 16'd8192, 16'd0, 16'd0, 16'd0);
        push_step(1'b0, 16'd2048, 16'd2047, 16'd0, 16'd0);
        push_step(1'b0, 16'd1024, 16'd3072, 16'd0, 16'd0);
        push_step(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_step(1'b0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
        push_step(1'b0, 16'd0, 16'd0, 16'hFFFF, 16'd0);
        wait_drained();

        // zero dominance threshold and zero floor: zero total counts as dominated
        write_reg(REG_DOM_THRESH, 24'd0);
        write_reg(REG_STEP_FLOOR, 24'd0);
        close_writes();
        push_step(1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
        push_step(1'b0, 16'd4096, 16'd0, 16'd0, 16'd0);
        wait_drained();

        // threshold above one: dominance can no longer hold
        write_reg(REG_DOM_THRESH, 24'd8191);
        close_writes();
        push_step(1'b0, 16'd0, 16'd4096, 16'd0, 16'd0);
        push_step(1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
        wait_drained();

        // zero cap forces exit on every step
        write_reg(REG_STEP_CAP, 24'd0);
        close_writes();
        push_step(1'b1, 16'd8192, 16'd0, 16'd0, 16'd0);
        push_step(1'b0, 16'd0, 16'd8192, 16'd0, 16'd0);
        wait_drained();

        // one long trace at full rate runs well past the step cap
        write_reg(REG_STEP_CAP, 24'd16);
        write_reg(REG_DOM_THRESH, 24'(RST_DOM_THRESH));
        close_writes();
        full_rate = 1'b1;
        push_step(1'b1, 16'hFFFF, 16'hFFFF, pick_level(), pick_level());
        repeat (LONG_STEPS - 1) push_step(1'b0, 16'hFFFF, 16'hFFFF, pick_level(), pick_level());
        wait_drained();
        full_rate = 1'b0;

        // random traces over several register settings, the extremes first
        for (int set_no = 0; set_no < RAND_SETS; set_no++) begin
            program_regs(set_no == 0 ? SET_MAXIMA : set_no == 1 ? SET_MINIMA : SET_RANDOM);
            if (set_no == 3) begin
                // sender keeps offering while the receiver holds off
                full_rate    = 1'b1;
                hold_request = HOLD_LONG;
            end
            repeat (RAND_STEPS) begin
                steps_to_send.push_back(random_step());
                steps_queued++;
            end
            wait_drained();
            full_rate = 1'b0;
        end

        repeat (8) @(posedge aclk);
        $display("checked %0d result beats from %0d steps in %0d traces, %0d register settings",
                 result_beats, steps_accepted, traces_started, settings_run);
        $display("verdicts seen: continue %0d, exit %0d, expand %0d, abstain %0d",
                 verdict_seen[VERDICT_CONTINUE], verdict_seen[VERDICT_EXIT],
                 verdict_seen[VERDICT_EXPAND], verdict_seen[VERDICT_ABSTAIN]);
        if (mismatches == 0) begin
            $display("early_exit_budget_decider_unit: match");
        end else begin
            $display("early_exit_budget_decider_unit: mismatch");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin : watchdog
        #1_000_000;
        $display("timeout with %0d results outstanding", steps_queued - result_beats);
        $display("early_exit_budget_decider_unit: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/eebd_pkg.sv
rtl/core/eebd_cfg.sv
rtl/core/eebd_prod.sv
rtl/core/eebd_decide.sv
rtl/core/early_exit_budget_decider_unit.sv
rtl/core/eebd_chk.sv
dv/testbench.sv
